// File: design/mhd_pkg.sv
// Shared types and constants for the message header deframer.
package mhd_pkg;

  localparam logic [31:0] MAGIC_FWD    = 32'h0ABC_DEF0;
  localparam logic [31:0] MAGIC_REV    = 32'h0FED_CBA0;
  localparam logic [15:0] CLASS_MODERN = 16'h6414;
  localparam logic [15:0] CLASS_ZERO   = 16'h0000;

  localparam int unsigned POS_W = 5;

  // Header byte positions that end a field or decide the header form
  localparam logic [POS_W-1:0] POS_MAGIC_END   = 5'd3;
  localparam logic [POS_W-1:0] POS_CMD_END     = 5'd7;
  localparam logic [POS_W-1:0] POS_LEN_END     = 5'd11;
  localparam logic [POS_W-1:0] POS_CHANNEL     = 5'd12;
  localparam logic [POS_W-1:0] POS_MSGID_END   = 5'd15;
  localparam logic [POS_W-1:0] POS_STATUS_END  = 5'd17;
  localparam logic [POS_W-1:0] POS_CLASS_END   = 5'd19;
  localparam logic [POS_W-1:0] POS_OFFSET_END  = 5'd23;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_BODY      = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] command_id;
    logic [7:0]  channel_id;
    logic [15:0] reply_status;
    logic [15:0] message_class;
    logic        is_modern;
    logic [31:0] split_offset;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        last;
  } res_t;

  // Handshake between parser and result register
  typedef struct packed {
    logic valid;
    res_t data;
  } res_xfer_t;

endpackage

// File: design/mhd_if.sv
// Channel interfaces: received byte stream and deframed results.
interface mhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mhd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] command_id;
  logic [7:0]  channel_id;
  logic [15:0] reply_status;
  logic [15:0] message_class;
  logic        is_modern;
  logic [31:0] split_offset;
  logic [31:0] body_length;
  logic [7:0]  body_byte;
  logic        last;

  modport source (output valid, output kind, output command_id, output channel_id,
                  output reply_status, output message_class, output is_modern,
                  output split_offset, output body_length, output body_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input command_id, input channel_id,
                input reply_status, input message_class, input is_modern,
                input split_offset, input body_length, input body_byte,
                input last, output ready);
endinterface

// File: design/mhd_parse.sv
// Input byte register, header collection state and result formation.
module mhd_parse (
  input  logic               clk,
  input  logic               rst_n,
  mhd_in_if.sink             in_ch,
  input  logic               out_free,
  output mhd_pkg::res_xfer_t res
);
  import mhd_pkg::*;

  typedef enum logic {
    PH_HEADER,
    PH_BODY
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic [31:0]      magic_r, magic_nxt;
  logic [31:0]      cmd_r, cmd_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic [15:0]      status_r, status_nxt;
  logic [15:0]      class_r, class_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic             adv;
  logic             emit_hdr;
  logic             modern;
  res_t             r;
  logic             r_valid;

  assign adv          = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || adv;

  always_comb begin
    magic_nxt  = magic_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    ch_nxt     = ch_r;
    status_nxt = status_r;
    class_nxt  = class_r;
    offset_nxt = offset_r;
    remain_nxt = remain_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    emit_hdr   = 1'b0;
    modern     = 1'b0;
    r          = '0;
    r_valid    = 1'b0;

    if (phase_r == PH_BODY) begin
      remain_nxt  = remain_r - 32'd1;
      r.kind      = KIND_BODY;
      r.body_byte = s1_byte_r;
      r.last      = (remain_nxt == 32'd0);
      r_valid     = 1'b1;
      if (remain_nxt == 32'd0) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
      end
    end else begin
      // Insert the byte into the field its position belongs to
      if (pos_r <= POS_MAGIC_END) begin
        magic_nxt[pos_r[1:0]*8 +: 8] = s1_byte_r;
      end else if (pos_r <= POS_CMD_END) begin
        cmd_nxt[pos_r[1:0]*8 +: 8] = s1_byte_r;
      end else if (pos_r <= POS_LEN_END) begin
        len_nxt[pos_r[1:0]*8 +: 8] = s1_byte_r;
      end else if (pos_r == POS_CHANNEL) begin
        ch_nxt = s1_byte_r;
      end else if (pos_r <= POS_MSGID_END) begin
        ch_nxt = ch_r;  // message id bytes are dropped
      end else if (pos_r <= POS_STATUS_END) begin
        status_nxt[pos_r[0]*8 +: 8] = s1_byte_r;
      end else if (pos_r <= POS_CLASS_END) begin
        class_nxt[pos_r[0]*8 +: 8] = s1_byte_r;
      end else begin
        offset_nxt[pos_r[1:0]*8 +: 8] = s1_byte_r;
      end

      pos_nxt = pos_r + 5'd1;

      if (pos_r == POS_MAGIC_END && magic_nxt != MAGIC_FWD && magic_nxt != MAGIC_REV) begin
        r.kind  = KIND_BAD_MAGIC;
        r.last  = 1'b1;
        r_valid = 1'b1;
        pos_nxt = '0;
      end else if (pos_r == POS_CLASS_END && class_nxt != CLASS_MODERN &&
                   class_nxt != CLASS_ZERO) begin
        emit_hdr = 1'b1;
      end else if (pos_r >= POS_OFFSET_END) begin
        emit_hdr = 1'b1;
        modern   = 1'b1;
      end

      if (emit_hdr) begin
        r.kind           = KIND_HEADER;
        r.command_id     = cmd_r;
        r.channel_id     = ch_r;
        r.reply_status   = status_r;
        r.message_class  = class_nxt;
        r.is_modern      = modern;
        r.split_offset   = modern ? offset_nxt : 32'd0;
        r.body_length    = len_r;
        r.last           = (len_r == 32'd0);
        r_valid          = 1'b1;
        pos_nxt          = '0;
        remain_nxt       = len_r;
        phase_nxt        = (len_r != 32'd0) ? PH_BODY : PH_HEADER;
      end
    end
  end

  assign res.valid = adv && r_valid;
  assign res.data  = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      remain_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        remain_r <= remain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (adv) begin
      magic_r  <= magic_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      ch_r     <= ch_nxt;
      status_r <= status_nxt;
      class_r  <= class_nxt;
      offset_r <= offset_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_OFFSET_END)
    else $error("header position out of range");

  a_body_remain: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> (remain_r != 32'd0 && pos_r == '0))
    else $error("body phase with nothing left or stale position");

  a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (s1_valid_r && out_free))
    else $error("result produced without room downstream");

endmodule

// File: design/mhd_out_reg.sv
// Result register that holds a finished result until the sink takes it.
module mhd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  mhd_pkg::res_xfer_t res,
  output logic               out_free,
  mhd_out_if.source          out_ch
);
  import mhd_pkg::*;

  logic valid_r;
  res_t data_r;

  assign out_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      data_r <= res.data;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = data_r.kind;
  assign out_ch.command_id     = data_r.command_id;
  assign out_ch.channel_id     = data_r.channel_id;
  assign out_ch.reply_status   = data_r.reply_status;
  assign out_ch.message_class  = data_r.message_class;
  assign out_ch.is_modern      = data_r.is_modern;
  assign out_ch.split_offset   = data_r.split_offset;
  assign out_ch.body_length    = data_r.body_length;
  assign out_ch.body_byte      = data_r.body_byte;
  assign out_ch.last           = data_r.last;

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |=> (valid_r && $stable(data_r)))
    else $error("pending result changed before transfer");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |-> !res.valid)
    else $error("new result offered while register is full");

  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.kind == KIND_BAD_MAGIC) |-> (data_r.last && data_r.body_length == 32'd0))
    else $error("bad magic result carries header data");

endmodule

// File: design/message_header_deframer_core.sv
// Top level of the message header deframer.
//
//   channel  dir  payload                                   transfer when
//   in_ch    in   rx_byte                                   valid && ready
//   out_ch   out  kind, header fields, body_byte, last      valid && ready
//
// One byte per cycle sustained while the output takes results: a byte
// waits in the input register, then the header/body logic forms its result
// into the result register, whose valid output is the result valid; an output
// stall holds the byte in the input register until the result register frees.
// Header bytes that complete nothing give no result.
// Synchronous active-low reset returns to header collection at position 0.
// A stalled output holds its result; input keeps flowing until both
// registers are full.
module message_header_deframer_core (
  input  logic      clk,
  input  logic      rst_n,
  mhd_in_if.sink    in_ch,
  mhd_out_if.source out_ch
);
  import mhd_pkg::*;

  res_xfer_t res;
  logic      out_free;

  mhd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .res      (res)
  );

  mhd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// File: tb/message_header_deframer_core_test.sv
// Self-checking testbench for message_header_deframer_core: directed table, then random streams.
module message_header_deframer_core_test;
  import mhd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 800;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       exp;
  } stim_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_PATTERN,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       src_valid = 1'b0;
  logic [7:0] src_byte = 8'h00;
  logic       sink_ready = 1'b0;

  mhd_in_if  in_ch ();
  mhd_out_if out_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.rx_byte = src_byte;
  assign out_ch.ready  = sink_ready;

  message_header_deframer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_row_t stream_rows[$];
  res_t      pending_results[$];

  // Predictor state
  bit          in_body = 1'b0;
  logic [4:0]  hdr_pos = '0;
  logic [31:0] magic_acc = '0;
  logic [31:0] cmd_acc = '0;
  logic [31:0] len_acc = '0;
  logic [7:0]  chan_acc = '0;
  logic [15:0] status_acc = '0;
  logic [15:0] class_acc = '0;
  logic [31:0] offset_acc = '0;
  logic [31:0] body_left = '0;

  int fail_count = 0;
  int bytes_taken = 0;
  int send_idx = 0;
  int gap_left = 0;
  int burst_left = 1;
  int idle_cycles = 0;
  int hdr_seen = 0;
  int long_seen = 0;
  int body_seen = 0;
  int bad_seen = 0;

  ready_mode_t ready_mode = RDY_ALWAYS;
  logic [15:0] ready_pattern = '1;
  logic [5:0]  ready_cycle = '0;

  // Long-form header, empty body, all-ones fields and an offset past the body
  logic [7:0] long_hdr [24] = '{
    8'hA0, 8'hCB, 8'hED, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A,
    8'hFF, 8'hFF, 8'h14, 8'h64, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic deframe_byte(input logic [7:0] b, output bit got, output res_t r);
    bit modern;
    r = '0;
    got = 1'b0;
    if (in_body) begin
      if (body_left != 0) body_left = body_left - 1;
      r.kind = KIND_BODY;
      r.body_byte = b;
      r.last = (body_left == 0);
      got = 1'b1;
      if (body_left == 0) begin
        in_body = 1'b0;
        hdr_pos = '0;
      end
    end else begin
      if (hdr_pos <= POS_MAGIC_END) magic_acc[{hdr_pos[1:0], 3'b000} +: 8] = b;
      else if (hdr_pos <= POS_CMD_END) cmd_acc[{hdr_pos[1:0], 3'b000} +: 8] = b;
      else if (hdr_pos <= POS_LEN_END) len_acc[{hdr_pos[1:0], 3'b000} +: 8] = b;
      else if (hdr_pos == POS_CHANNEL) chan_acc = b;
      else if (hdr_pos <= POS_MSGID_END) begin
        // drop message id bytes
      end
      else if (hdr_pos <= POS_STATUS_END) status_acc[{hdr_pos[0], 3'b000} +: 8] = b;
      else if (hdr_pos <= POS_CLASS_END) class_acc[{hdr_pos[0], 3'b000} +: 8] = b;
      else offset_acc[{hdr_pos[1:0], 3'b000} +: 8] = b;

      if (hdr_pos == POS_MAGIC_END && magic_acc != MAGIC_FWD && magic_acc != MAGIC_REV) begin
        r.kind = KIND_BAD_MAGIC;
        r.last = 1'b1;
        got = 1'b1;
        hdr_pos = '0;
      end else if ((hdr_pos == POS_CLASS_END && class_acc != CLASS_MODERN &&
                    class_acc != CLASS_ZERO) || hdr_pos == POS_OFFSET_END) begin
        modern = (hdr_pos == POS_OFFSET_END);
        r.kind = KIND_HEADER;
        r.command_id = cmd_acc;
        r.channel_id = chan_acc;
        r.reply_status = status_acc;
        r.message_class = class_acc;
        r.is_modern = modern;
        r.split_offset = modern ? offset_acc : '0;
        r.body_length = len_acc;
        r.last = (len_acc == 0);
        got = 1'b1;
        hdr_pos = '0;
        in_body = (len_acc != 0);
        body_left = len_acc;
      end else begin
        hdr_pos = hdr_pos + 5'd1;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_row_t row;
    row.rx = b;
    row.typed = 1'b0;
    row.exp = '0;
    stream_rows = {stream_rows, row};
  endtask

  task automatic add_word(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) add_byte(w[8*i +: 8]);
  endtask

  // Bias toward all-zeros and all-ones words
  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus build, reset and end of run
  initial begin
    res_t        bad_magic_res;
    res_t        empty_hdr_res;
    logic [31:0] w;
    logic [31:0] len;
    logic [15:0] cls;
    int          roll;
    int          directed_count;

    bad_magic_res = '0;
    bad_magic_res.kind = KIND_BAD_MAGIC;
    bad_magic_res.last = 1'b1;

    empty_hdr_res = '0;
    empty_hdr_res.kind = KIND_HEADER;
    empty_hdr_res.command_id = '1;
    empty_hdr_res.channel_id = '1;
    empty_hdr_res.reply_status = '1;
    empty_hdr_res.message_class = CLASS_MODERN;
    empty_hdr_res.is_modern = 1'b1;
    empty_hdr_res.split_offset = '1;
    empty_hdr_res.body_length = '0;
    empty_hdr_res.last = 1'b1;

    add_word('1, 4);
    stream_rows[$].typed = 1'b1;
    stream_rows[$].exp = bad_magic_res;
    foreach (long_hdr[i]) add_byte(long_hdr[i]);
    stream_rows[$].typed = 1'b1;
    stream_rows[$].exp = empty_hdr_res;
    directed_count = stream_rows.size();

    while (stream_rows.size() < directed_count + RANDOM_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        // broken magic: near miss or random word
        w = $urandom_range(0, 1) ? MAGIC_FWD : MAGIC_REV;
        if ($urandom_range(0, 1)) w[$urandom_range(0, 31)] ^= 1'b1;
        else w = $urandom;
        if (w == MAGIC_FWD || w == MAGIC_REV) w ^= 32'h1;
        add_word(w, 4);
      end else begin
        add_word($urandom_range(0, 1) ? MAGIC_FWD : MAGIC_REV, 4);
        add_word(pick_word(), 4);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 6);
        add_word(len, 4);
        add_word(pick_word(), 1);
        add_word(pick_word(), 3);
        add_word(pick_word(), 2);
        roll = $urandom_range(0, 9);
        if (roll < 3) cls = CLASS_MODERN;
        else if (roll < 5) cls = CLASS_ZERO;
        else if (roll < 6) cls = CLASS_MODERN ^ (16'h1 << $urandom_range(0, 15));
        else begin
          w = pick_word();
          cls = w[15:0];
        end
        add_word({16'h0000, cls}, 2);
        if (cls == CLASS_MODERN || cls == CLASS_ZERO) add_word(pick_word(), 4);
        for (int i = 0; i < len; i++) add_byte($urandom_range(0, 255));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < stream_rows.size() || pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes (%0d directed): %0d headers, %0d of them long form,",
             stream_rows.size(), directed_count, hdr_seen, long_seen);
    $display("%0d body bytes and %0d bad-magic restarts checked", body_seen, bad_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    int nxt;
    nxt = send_idx + ((in_ch.valid && in_ch.ready) ? 1 : 0);
    send_idx <= nxt;
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the offered byte
    end else if (gap_left > 0) begin
      src_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (nxt < stream_rows.size()) begin
      src_valid <= 1'b1;
      src_byte <= stream_rows[nxt].rx;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 48);
        if ($urandom_range(0, 2) == 0) gap_left <= 0;
        else if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(8, 24);
        else gap_left <= $urandom_range(1, 4);
      end
    end else begin
      src_valid <= 1'b0;
    end
  end

  // Receiver: stall mode is picked anew each time the 6-bit cycle counter wraps
  always @(posedge clk) begin
    if (ready_cycle == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_pattern <= 16'($urandom);
    end
    ready_cycle <= ready_cycle + 6'd1;
    case (ready_mode)
      RDY_ALWAYS:  sink_ready <= 1'b1;
      RDY_PATTERN: sink_ready <= ready_pattern[ready_cycle[3:0]];
      RDY_SPARSE:  sink_ready <= ($urandom_range(0, 3) == 0);
      default:     sink_ready <= ready_pattern[ready_cycle[4:1]] | ready_pattern[ready_cycle[3:0]];
    endcase
  end

  // Input monitor: advance the predictor on every accepted byte
  always @(posedge clk) begin
    bit   got;
    res_t pred;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      deframe_byte(in_ch.rx_byte, got, pred);
      if (stream_rows[bytes_taken].typed) begin
        pending_results = {pending_results, stream_rows[bytes_taken].exp};
      end else if (got) begin
        pending_results = {pending_results, pred};
      end
      bytes_taken <= bytes_taken + 1;
    end
  end

  // Output monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: kind 0x%0h", out_ch.kind);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_ch.kind));
        check_field("command_id", want.command_id, out_ch.command_id);
        check_field("channel_id", 32'(want.channel_id), 32'(out_ch.channel_id));
        check_field("reply_status", 32'(want.reply_status), 32'(out_ch.reply_status));
        check_field("message_class", 32'(want.message_class), 32'(out_ch.message_class));
        check_field("is_modern", 32'(want.is_modern), 32'(out_ch.is_modern));
        check_field("split_offset", want.split_offset, out_ch.split_offset);
        check_field("body_length", want.body_length, out_ch.body_length);
        check_field("body_byte", 32'(want.body_byte), 32'(out_ch.body_byte));
        check_field("last", 32'(want.last), 32'(out_ch.last));
        case (want.kind)
          KIND_HEADER: begin
            hdr_seen++;
            if (want.is_modern) long_seen++;
          end
          KIND_BODY: body_seen++;
          default:   bad_seen++;
        endcase
      end
    end
  end

  // Watchdog: count cycles without any transfer while work is outstanding
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (bytes_taken < stream_rows.size() || pending_results.size() != 0) begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $error("no transfer for %0d cycles with %0d results outstanding",
                 idle_cycles, pending_results.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

endmodule

// File: message_header_deframer_core.f
design/mhd_pkg.sv
design/mhd_if.sv
design/mhd_parse.sv
design/mhd_out_reg.sv
design/message_header_deframer_core.sv
tb/message_header_deframer_core_test.sv
